[rtl/spmsc_pkg.sv]
// shared types and constants of the module structure checker
`default_nettype none

package spmsc_pkg;

  // header framing
  localparam int unsigned HeaderWords = 5;
  localparam int unsigned HdrW        = 3;
  localparam int unsigned CountShift  = 16;
  localparam int unsigned CountW      = 16;
  localparam logic [31:0] VersionMask = 32'h00FF_0000;
  localparam logic [31:0] MagicReset  = 32'h0723_0203;

  // configuration register indexes
  localparam logic [1:0] RegMagic = 2'd0;

  // word queue between front and back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);

  // verdict reason codes
  typedef enum logic [3:0] {
    R_OK         = 4'd0,
    R_SHORT      = 4'd1,
    R_MISALIGNED = 4'd2,
    R_MAGIC      = 4'd3,
    R_VERSION    = 4'd4,
    R_BOUND      = 4'd5,
    R_SCHEMA     = 4'd6,
    R_ZERO_COUNT = 4'd7,
    R_OVERRUN    = 4'd8
  } reason_t;

  // one queue entry: an assembled word and/or the end of a module
  typedef struct packed {
    logic [31:0] word;
    logic        has_word;
    logic        is_last;
    logic        misaligned;
  } entry_t;

endpackage

`default_nettype wire

[rtl/spmsc_front.sv]
// byte assembler: builds little endian words and marks the module end
`default_nettype none

module spmsc_front
  import spmsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            push,
  output entry_t          push_entry
);

  logic [1:0]  lane_r, lane_nxt;
  logic [23:0] partial_r, partial_nxt;
  logic        word_done;

  // lane 3 completes the word
  assign word_done = (lane_r == 2'd3);

  always_comb begin
    partial_nxt = partial_r;
    lane_nxt    = lane_r + 2'd1;
    case (lane_r)
      2'd0:    partial_nxt = {16'h0000, data_byte};
      2'd1:    partial_nxt = {8'h00, data_byte, partial_r[7:0]};
      2'd2:    partial_nxt = {data_byte, partial_r[15:0]};
      default: partial_nxt = 24'h000000;
    endcase
    // a new module starts after the last byte
    if (last_byte) begin
      lane_nxt    = 2'd0;
      partial_nxt = 24'h000000;
    end
  end

  // queue entry for word completion or module end
  assign push                  = take && (word_done || last_byte);
  assign push_entry.word       = {data_byte, partial_r};
  assign push_entry.has_word   = word_done;
  assign push_entry.is_last    = last_byte;
  assign push_entry.misaligned = !word_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r    <= 2'd0;
      partial_r <= 24'h000000;
    end else if (take) begin
      lane_r    <= lane_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/spmsc_fifo.sv]
// short show-ahead queue of word entries between front and back
`default_nettype none

module spmsc_fifo
  import spmsc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      pop_entry,
  output logic        empty,
  output logic        full
);

  entry_t            mem [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_r, rd_ptr_r;
  logic [FifoCw-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign empty     = (cnt_r == FifoCw'(0));
  assign full      = (cnt_r == FifoCw'(FifoDepth));
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = mem[rd_ptr_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + FifoCw'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - FifoCw'(1);
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_entry;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + FifoAw'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + FifoAw'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/spmsc_back.sv]
// word checker: header checks, instruction countdown and verdict register
`default_nettype none

module spmsc_back
  import spmsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [31:0] magic,
  input  wire entry_t      entry,
  input  wire logic        entry_avail,
  output logic             pop,
  input  wire logic        out_ready,
  output logic             out_valid,
  output reason_t          out_reason
);

  logic [HdrW-1:0]   hdr_r, hdr_nxt;
  logic [CountW-1:0] left_r, left_nxt, count;
  reason_t           err_r, err_nxt, verdict, err_hit;
  logic              out_valid_r;
  reason_t           out_reason_r;
  logic              out_space;

  assign out_space = !out_valid_r || out_ready;
  assign pop       = entry_avail && (!entry.is_last || out_space);
  assign count     = entry.word[CountShift +: CountW];

  // word checks
  always_comb begin
    hdr_nxt  = hdr_r;
    left_nxt = left_r;
    err_hit  = R_OK;
    if (entry.has_word) begin
      if (hdr_r < HdrW'(HeaderWords)) begin
        unique case (hdr_r)
          3'd0:    if (entry.word != magic) err_hit = R_MAGIC;
          3'd1:    if ((entry.word & VersionMask) == 32'h0) err_hit = R_VERSION;
          3'd3:    if (entry.word == 32'h0) err_hit = R_BOUND;
          3'd4:    if (entry.word != 32'h0) err_hit = R_SCHEMA;
          default: err_hit = R_OK;
        endcase
        hdr_nxt = hdr_r + HdrW'(1);
      end else if (left_r != '0) begin
        left_nxt = left_r - CountW'(1);
      end else if (count == '0) begin
        err_hit = R_ZERO_COUNT;
      end else begin
        left_nxt = count - CountW'(1);
      end
    end
    err_nxt = (err_r == R_OK) ? err_hit : err_r;
  end

  // verdict with precedence
  always_comb begin
    if (hdr_nxt < HdrW'(HeaderWords))   verdict = R_SHORT;
    else if (entry.misaligned)          verdict = R_MISALIGNED;
    else if (err_nxt != R_OK)           verdict = err_nxt;
    else if (left_nxt != '0)            verdict = R_OVERRUN;
    else                                verdict = R_OK;
  end

  // stream state, cleared after each verdict
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r  <= '0;
      left_r <= '0;
      err_r  <= R_OK;
    end else if (pop) begin
      if (entry.is_last) begin
        hdr_r  <= '0;
        left_r <= '0;
        err_r  <= R_OK;
      end else begin
        hdr_r  <= hdr_nxt;
        left_r <= left_nxt;
        err_r  <= err_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      out_reason_r <= R_OK;
    end else if (out_space) begin
      out_valid_r  <= pop && entry.is_last;
      out_reason_r <= verdict;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_reason = out_reason_r;

endmodule

`default_nettype wire

[rtl/spirv_module_structure_checker_core.sv]
// top level of the module structure checker
//
//  channel | direction | payload
//  in_     | slave     | tdata[7:0] data_byte, tlast last_byte
//  out_    | master    | tdata[0] module_valid, [4:1] fail_reason, [7:5] zero
//  cfg_    | apb       | reg 0 at 0x0: magic_word
//
// One byte is taken per cycle while in_tready is high. A byte that completes a word
// or ends the module enters a four-entry queue; the checker behind it handles one
// entry per cycle, and the verdict is registered at the checker's output.
// Reset is synchronous and active low; magic_word resets to 0x07230203.
// The checker waits only while a verdict is held by out_tready low; the queue
// then fills and in_tready falls.
`default_nettype none

module spirv_module_structure_checker_core
  import spmsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // last_byte
  // verdict stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [0] module_valid, [4:1] fail_reason, [7:5] zero
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [31:0] magic_r;
  logic        cfg_wr;
  logic        take, push, pop, fifo_empty, fifo_full;
  entry_t      push_entry, pop_entry;
  reason_t     out_reason;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr == RegMagic);
  assign cfg_prdata = (cfg_paddr == RegMagic) ? magic_r : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= MagicReset;
    end else if (cfg_wr) begin
      magic_r <= cfg_pwdata;
    end
  end

  // input transaction
  assign in_tready = !fifo_full;
  assign take      = in_tvalid && in_tready;

  spmsc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .data_byte  (in_tdata),
    .last_byte  (in_tlast),
    .push       (push),
    .push_entry (push_entry)
  );

  spmsc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (fifo_empty),
    .full       (fifo_full)
  );

  spmsc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .magic       (magic_r),
    .entry       (pop_entry),
    .entry_avail (!fifo_empty),
    .pop         (pop),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_reason  (out_reason)
  );

  // result packing
  assign out_tdata = {3'b000, out_reason, (out_reason == R_OK)};

  // checks
  a_valid_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[4:1] == R_OK)))
    else $error("module_valid disagrees with fail_reason");

  a_reason_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4:1] <= R_OVERRUN))
    else $error("fail_reason out of range");

  a_end_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && pop_entry.is_last) |-> (!out_tvalid || out_tready))
    else $error("verdict overwrote a held result");

endmodule

`default_nettype wire
